### hw/rtl/qva_pkg.sv
// qva_pkg: shared types and constants of the quaternion/vector ALU.
// Request and result structs, operation codes and datapath widths.
// No dependencies.
package qva_pkg;

    localparam int OPW    = 32;
    localparam int PROD_W = 2 * OPW;
    localparam int PAIR_W = PROD_W + 1;
    localparam int ACC_W  = PROD_W + 2;
    localparam int LANES  = 4;
    localparam int SLOTS  = 4;

    typedef enum logic [3:0] {
        OP_VADD     = 4'd0,
        OP_VSUB     = 4'd1,
        OP_VSCALE   = 4'd2,
        OP_VDOT     = 4'd3,
        OP_VCROSS   = 4'd4,
        OP_QADD     = 4'd5,
        OP_QSUB     = 4'd6,
        OP_QSCALE   = 4'd7,
        OP_QPROD    = 4'd8,
        OP_QCONJ    = 4'd9,
        OP_QDOT     = 4'd10,
        OP_VOUTER   = 4'd11,
        OP_VGEOM    = 4'd12,
        OP_QVECPROD = 4'd13
    } op_t;

    typedef struct packed {
        logic        [3:0]     req_type;
        logic signed [OPW-1:0] a_w;
        logic signed [OPW-1:0] a_x;
        logic signed [OPW-1:0] a_y;
        logic signed [OPW-1:0] a_z;
        logic signed [OPW-1:0] b_w;
        logic signed [OPW-1:0] b_x;
        logic signed [OPW-1:0] b_y;
        logic signed [OPW-1:0] b_z;
        logic signed [OPW-1:0] scale;
    } req_t;

    typedef struct packed {
        logic signed [OPW-1:0] r_w;
        logic signed [OPW-1:0] r_x;
        logic signed [OPW-1:0] r_y;
        logic signed [OPW-1:0] r_z;
        logic                  saturated;
    } rsp_t;

endpackage

### hw/rtl/quaternion_vector_alu_core.sv
// quaternion_vector_alu_core: pipelined fixed-point vector/quaternion ALU.
// Depends on qva_pkg (request/result structs, op codes, widths).
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+-----------------------------------
//  request  | start, busy, request (req_t)  | taken on clk when start && !busy
//  result   | done, result (rsp_t)          | done high one cycle, no back-pressure
//
// One request per cycle while busy is low; each result passes through these registered stages:
// operand select, 16 multipliers, pair adds, lane add, shift and clamp.
// busy is set by reset and cleared at the first clock edge after reset is released.
// Nothing stalls: the pipeline advances every cycle and valid bits follow the data.
module quaternion_vector_alu_core
    import qva_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
)(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t result
);

    localparam logic signed [OPW-1:0]   ONE     = OPW'(1) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ONE_ACC = ACC_W'(1);
    localparam logic signed [ACC_W-1:0] MAX_V   = (ONE_ACC <<< (WORD_BITS - 1)) - ONE_ACC;
    localparam logic signed [ACC_W-1:0] MIN_V   = -MAX_V - ONE_ACC;

    logic busy_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg, done_reg;
    logic accept;

    logic signed [OPW-1:0]    x_next [LANES][SLOTS];
    logic signed [OPW-1:0]    y_next [LANES][SLOTS];
    logic                     n_next [LANES][SLOTS];
    logic signed [OPW-1:0]    x_reg  [LANES][SLOTS];
    logic signed [OPW-1:0]    y_reg  [LANES][SLOTS];
    logic                     n1_reg [LANES][SLOTS];
    logic signed [PROD_W-1:0] p_reg  [LANES][SLOTS];
    logic                     n2_reg [LANES][SLOTS];
    logic signed [PAIR_W-1:0] pair_next [LANES][2];
    logic signed [PAIR_W-1:0] pair_reg  [LANES][2];
    logic signed [ACC_W-1:0]  sum_next  [LANES];
    logic signed [ACC_W-1:0]  sum_reg   [LANES];
    logic signed [OPW-1:0]    lane_next [LANES];
    logic [LANES-1:0]         sat_next;
    rsp_t                     result_reg;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    // operand select
    always_comb
    begin
        logic signed [OPW-1:0] bwq;
        logic                  sub;
        bwq = (request.req_type == OP_QVECPROD) ? '0 : request.b_w;
        sub = (request.req_type == OP_VSUB) || (request.req_type == OP_QSUB);
        for (int l = 0; l < LANES; l++)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                x_next[l][k] = '0;
                y_next[l][k] = '0;
                n_next[l][k] = 1'b0;
            end
        end
        unique case (request.req_type) inside
            OP_VADD, OP_VSUB, OP_QADD, OP_QSUB:
            begin
                if (request.req_type == OP_QADD || request.req_type == OP_QSUB)
                begin
                    x_next[0][0] = request.a_w; y_next[0][0] = ONE;
                    x_next[0][1] = request.b_w; y_next[0][1] = ONE; n_next[0][1] = sub;
                end
                x_next[1][0] = request.a_x; y_next[1][0] = ONE;
                x_next[1][1] = request.b_x; y_next[1][1] = ONE; n_next[1][1] = sub;
                x_next[2][0] = request.a_y; y_next[2][0] = ONE;
                x_next[2][1] = request.b_y; y_next[2][1] = ONE; n_next[2][1] = sub;
                x_next[3][0] = request.a_z; y_next[3][0] = ONE;
                x_next[3][1] = request.b_z; y_next[3][1] = ONE; n_next[3][1] = sub;
            end
            OP_VSCALE, OP_QSCALE:
            begin
                if (request.req_type == OP_QSCALE)
                begin
                    x_next[0][0] = request.scale; y_next[0][0] = request.a_w;
                end
                x_next[1][0] = request.scale; y_next[1][0] = request.a_x;
                x_next[2][0] = request.scale; y_next[2][0] = request.a_y;
                x_next[3][0] = request.scale; y_next[3][0] = request.a_z;
            end
            OP_VDOT, OP_QDOT, OP_VGEOM:
            begin
                if (request.req_type == OP_QDOT)
                begin
                    x_next[0][0] = request.a_w; y_next[0][0] = request.b_w;
                end
                x_next[0][1] = request.a_x; y_next[0][1] = request.b_x;
                x_next[0][2] = request.a_y; y_next[0][2] = request.b_y;
                x_next[0][3] = request.a_z; y_next[0][3] = request.b_z;
                if (request.req_type == OP_VGEOM)
                begin
                    x_next[1][0] = request.a_x; y_next[1][0] = request.b_y;
                    x_next[1][1] = request.a_y; y_next[1][1] = request.b_x; n_next[1][1] = 1'b1;
                    x_next[2][0] = request.a_x; y_next[2][0] = request.b_z;
                    x_next[2][1] = request.a_z; y_next[2][1] = request.b_x; n_next[2][1] = 1'b1;
                    x_next[3][0] = request.a_y; y_next[3][0] = request.b_z;
                    x_next[3][1] = request.a_z; y_next[3][1] = request.b_y; n_next[3][1] = 1'b1;
                end
            end
            OP_VCROSS:
            begin
                x_next[1][0] = request.a_y; y_next[1][0] = request.b_z;
                x_next[1][1] = request.a_z; y_next[1][1] = request.b_y; n_next[1][1] = 1'b1;
                x_next[2][0] = request.a_z; y_next[2][0] = request.b_x;
                x_next[2][1] = request.a_x; y_next[2][1] = request.b_z; n_next[2][1] = 1'b1;
                x_next[3][0] = request.a_x; y_next[3][0] = request.b_y;
                x_next[3][1] = request.a_y; y_next[3][1] = request.b_x; n_next[3][1] = 1'b1;
            end
            OP_VOUTER:
            begin
                x_next[1][0] = request.a_x; y_next[1][0] = request.b_y;
                x_next[1][1] = request.a_y; y_next[1][1] = request.b_x; n_next[1][1] = 1'b1;
                x_next[2][0] = request.a_x; y_next[2][0] = request.b_z;
                x_next[2][1] = request.a_z; y_next[2][1] = request.b_x; n_next[2][1] = 1'b1;
                x_next[3][0] = request.a_y; y_next[3][0] = request.b_z;
                x_next[3][1] = request.a_z; y_next[3][1] = request.b_y; n_next[3][1] = 1'b1;
            end
            OP_QPROD, OP_QVECPROD:
            begin
                x_next[0][0] = request.a_w; y_next[0][0] = bwq;
                x_next[0][1] = request.a_x; y_next[0][1] = request.b_x; n_next[0][1] = 1'b1;
                x_next[0][2] = request.a_y; y_next[0][2] = request.b_y; n_next[0][2] = 1'b1;
                x_next[0][3] = request.a_z; y_next[0][3] = request.b_z; n_next[0][3] = 1'b1;
                x_next[1][0] = request.a_w; y_next[1][0] = request.b_x;
                x_next[1][1] = bwq;         y_next[1][1] = request.a_x;
                x_next[1][2] = request.a_y; y_next[1][2] = request.b_z;
                x_next[1][3] = request.a_z; y_next[1][3] = request.b_y; n_next[1][3] = 1'b1;
                x_next[2][0] = request.a_w; y_next[2][0] = request.b_y;
                x_next[2][1] = bwq;         y_next[2][1] = request.a_y;
                x_next[2][2] = request.a_z; y_next[2][2] = request.b_x;
                x_next[2][3] = request.a_x; y_next[2][3] = request.b_z; n_next[2][3] = 1'b1;
                x_next[3][0] = request.a_w; y_next[3][0] = request.b_z;
                x_next[3][1] = bwq;         y_next[3][1] = request.a_z;
                x_next[3][2] = request.a_x; y_next[3][2] = request.b_y;
                x_next[3][3] = request.a_y; y_next[3][3] = request.b_x; n_next[3][3] = 1'b1;
            end
            OP_QCONJ:
            begin
                x_next[0][0] = request.a_w; y_next[0][0] = ONE;
                x_next[1][0] = request.a_x; y_next[1][0] = ONE; n_next[1][0] = 1'b1;
                x_next[2][0] = request.a_y; y_next[2][0] = ONE; n_next[2][0] = 1'b1;
                x_next[3][0] = request.a_z; y_next[3][0] = ONE; n_next[3][0] = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // signed pair adds with negation folded in, then the lane add
    always_comb
    begin
        logic signed [PAIR_W-1:0] t0, t1;
        for (int l = 0; l < LANES; l++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                t0 = PAIR_W'(p_reg[l][2*j]);
                t1 = PAIR_W'(p_reg[l][2*j+1]);
                if (n2_reg[l][2*j])
                    t0 = -t0;
                if (n2_reg[l][2*j+1])
                    t1 = -t1;
                pair_next[l][j] = t0 + t1;
            end
            sum_next[l] = ACC_W'(pair_reg[l][0]) + ACC_W'(pair_reg[l][1]);
        end
    end

    // shift and clamp
    always_comb
    begin
        logic signed [ACC_W-1:0] sh;
        for (int l = 0; l < LANES; l++)
        begin
            sh = sum_reg[l] >>> FRAC_BITS;
            if (sh > MAX_V)
            begin
                lane_next[l] = MAX_V[OPW-1:0];
                sat_next[l]  = 1'b1;
            end
            else if (sh < MIN_V)
            begin
                lane_next[l] = MIN_V[OPW-1:0];
                sat_next[l]  = 1'b1;
            end
            else
            begin
                lane_next[l] = sh[OPW-1:0];
                sat_next[l]  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                if (accept)
                begin
                    x_reg[l][k]  <= x_next[l][k];
                    y_reg[l][k]  <= y_next[l][k];
                    n1_reg[l][k] <= n_next[l][k];
                end
                if (v1_reg)
                begin
                    p_reg[l][k]  <= x_reg[l][k] * y_reg[l][k];
                    n2_reg[l][k] <= n1_reg[l][k];
                end
            end
            if (v2_reg)
            begin
                pair_reg[l][0] <= pair_next[l][0];
                pair_reg[l][1] <= pair_next[l][1];
            end
            if (v3_reg)
                sum_reg[l] <= sum_next[l];
        end
        if (v4_reg)
        begin
            result_reg.r_w       <= lane_next[0];
            result_reg.r_x       <= lane_next[1];
            result_reg.r_y       <= lane_next[2];
            result_reg.r_z       <= lane_next[3];
            result_reg.saturated <= |sat_next;
        end
    end

endmodule

### hw/rtl/qva_checker.sv
// qva_checker: port-level assertions for quaternion_vector_alu_core, plus its bind.
// Depends on qva_pkg and the port list of quaternion_vector_alu_core.
module qva_checker
    import qva_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input req_t request,
    input logic done,
    input rsp_t result
);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("result missing five cycles after request");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("result without matching request");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(request.req_type > OP_QVECPROD, 5))
        |-> (result == '0))
        else $error("unused op code gave nonzero result");

    a_vec_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(request.req_type == OP_VADD || request.req_type == OP_VSUB ||
                       request.req_type == OP_VSCALE || request.req_type == OP_VCROSS ||
                       request.req_type == OP_VOUTER, 5))
        |-> (result.r_w == '0))
        else $error("pure vector result has nonzero w");

endmodule

bind quaternion_vector_alu_core qva_checker u_qva_checker (.*);

### verif/quaternion_vector_alu_core_test.sv
// quaternion_vector_alu_core_test: self-checking testbench for the fixed-point
// vector/quaternion ALU. A predictor works out each request's result at full width.
// Needs qva_pkg and quaternion_vector_alu_core only.
module quaternion_vector_alu_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import qva_pkg::*;

    localparam int FRAC = 16;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int RANDOM_PER_PHASE = 642;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic signed [127:0] LANE_MAX = 128'sh7FFF_FFFF;
    localparam logic signed [127:0] LANE_MIN = -128'sh8000_0000;

    class alu_scoreboard;
        rsp_t pending_results[$];
        int   request_count;
        int   result_count;
        int   saturated_count;
        int   mismatch_count;
        int   orphan_count;

        function logic signed [127:0] term(longint x, longint y, bit neg);
            logic signed [127:0] xs;
            logic signed [127:0] ys;
            xs = x;
            ys = y;
            return neg ? -(xs * ys) : xs * ys;
        endfunction

        function logic [31:0] clamp_lane(logic signed [127:0] acc, inout bit sat);
            logic signed [127:0] shifted;
            shifted = acc >>> FRAC;
            if (shifted > LANE_MAX)
            begin
                sat = 1'b1;
                return WORD_MAX;
            end
            if (shifted < LANE_MIN)
            begin
                sat = 1'b1;
                return WORD_MIN;
            end
            return shifted[31:0];
        endfunction

        function rsp_t compute_result(req_t q);
            logic signed [127:0] lane [4];
            longint aw, ax, ay, az, bw, bx, by, bz, f, one;
            bit sat;
            bit neg;
            bit quat;
            rsp_t r;
            aw = $signed(q.a_w);
            ax = $signed(q.a_x);
            ay = $signed(q.a_y);
            az = $signed(q.a_z);
            bw = $signed(q.b_w);
            bx = $signed(q.b_x);
            by = $signed(q.b_y);
            bz = $signed(q.b_z);
            f  = $signed(q.scale);
            one = longint'(1) << FRAC;
            for (int i = 0; i < 4; i++)
                lane[i] = '0;
            sat  = 1'b0;
            neg  = (q.req_type == OP_VSUB) || (q.req_type == OP_QSUB);
            quat = (q.req_type == OP_QADD) || (q.req_type == OP_QSUB) ||
                   (q.req_type == OP_QSCALE);
            case (q.req_type)
                OP_VADD, OP_VSUB, OP_QADD, OP_QSUB:
                begin
                    if (quat)
                        lane[0] = term(aw, one, 0) + term(bw, one, neg);
                    lane[1] = term(ax, one, 0) + term(bx, one, neg);
                    lane[2] = term(ay, one, 0) + term(by, one, neg);
                    lane[3] = term(az, one, 0) + term(bz, one, neg);
                end
                OP_VSCALE, OP_QSCALE:
                begin
                    if (quat)
                        lane[0] = term(f, aw, 0);
                    lane[1] = term(f, ax, 0);
                    lane[2] = term(f, ay, 0);
                    lane[3] = term(f, az, 0);
                end
                OP_VDOT, OP_QDOT, OP_VGEOM:
                begin
                    lane[0] = term(ax, bx, 0) + term(ay, by, 0) + term(az, bz, 0);
                    if (q.req_type == OP_QDOT)
                        lane[0] = lane[0] + term(aw, bw, 0);
                    if (q.req_type == OP_VGEOM)
                    begin
                        lane[1] = term(ax, by, 0) + term(ay, bx, 1);
                        lane[2] = term(ax, bz, 0) + term(az, bx, 1);
                        lane[3] = term(ay, bz, 0) + term(az, by, 1);
                    end
                end
                OP_VCROSS:
                begin
                    lane[1] = term(ay, bz, 0) + term(az, by, 1);
                    lane[2] = term(az, bx, 0) + term(ax, bz, 1);
                    lane[3] = term(ax, by, 0) + term(ay, bx, 1);
                end
                OP_VOUTER:
                begin
                    lane[1] = term(ax, by, 0) + term(ay, bx, 1);
                    lane[2] = term(ax, bz, 0) + term(az, bx, 1);
                    lane[3] = term(ay, bz, 0) + term(az, by, 1);
                end
                OP_QPROD, OP_QVECPROD:
                begin
                    if (q.req_type == OP_QVECPROD)
                        bw = 0;
                    lane[0] = term(aw, bw, 0) + term(ax, bx, 1) + term(ay, by, 1) +
                              term(az, bz, 1);
                    lane[1] = term(aw, bx, 0) + term(bw, ax, 0) + term(ay, bz, 0) +
                              term(az, by, 1);
                    lane[2] = term(aw, by, 0) + term(bw, ay, 0) + term(az, bx, 0) +
                              term(ax, bz, 1);
                    lane[3] = term(aw, bz, 0) + term(bw, az, 0) + term(ax, by, 0) +
                              term(ay, bx, 1);
                end
                OP_QCONJ:
                begin
                    lane[0] = term(aw, one, 0);
                    lane[1] = term(ax, one, 1);
                    lane[2] = term(ay, one, 1);
                    lane[3] = term(az, one, 1);
                end
                default:
                begin
                end
            endcase
            r.r_w = clamp_lane(lane[0], sat);
            r.r_x = clamp_lane(lane[1], sat);
            r.r_y = clamp_lane(lane[2], sat);
            r.r_z = clamp_lane(lane[3], sat);
            r.saturated = sat;
            return r;
        endfunction

        function void log_request(req_t q);
            request_count++;
            pending_results.push_back(compute_result(q));
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (pending_results.size() == 0)
            begin
                orphan_count++;
                if (mismatch_count + orphan_count <= 10)
                    $display("unexpected result w=%h x=%h y=%h z=%h sat=%b",
                             got.r_w, got.r_x, got.r_y, got.r_z, got.saturated);
                return;
            end
            want = pending_results.pop_front();
            result_count++;
            if (want.saturated)
                saturated_count++;
            if (got.r_w !== want.r_w || got.r_x !== want.r_x || got.r_y !== want.r_y ||
                got.r_z !== want.r_z || got.saturated !== want.saturated)
            begin
                mismatch_count++;
                if (mismatch_count + orphan_count <= 10)
                begin
                    $display("mismatch on result %0d: expected w=%h x=%h y=%h z=%h sat=%b",
                             result_count, want.r_w, want.r_x, want.r_y, want.r_z,
                             want.saturated);
                    $display("                      actual   w=%h x=%h y=%h z=%h sat=%b",
                             got.r_w, got.r_x, got.r_y, got.r_z, got.saturated);
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t request = '0;
    logic done;
    rsp_t result;

    alu_scoreboard board = new();
    int idle_pct = 0;
    int cycle_count = 0;

    quaternion_vector_alu_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #2ns clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            board.log_request(request);
        if (done)
            board.check_result(result);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("quaternion_vector_alu_core_test failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(9))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2, 3, 4: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
            5: return $urandom_range(1) ? 32'h0001_0000 : 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic req_t random_request(logic [3:0] op);
        req_t q;
        q.req_type = op;
        q.a_w = rand_operand();
        q.a_x = rand_operand();
        q.a_y = rand_operand();
        q.a_z = rand_operand();
        q.b_w = rand_operand();
        q.b_x = rand_operand();
        q.b_y = rand_operand();
        q.b_z = rand_operand();
        q.scale = rand_operand();
        return q;
    endfunction

    function automatic req_t uniform_request(logic [3:0] op, logic [31:0] av,
                                             logic [31:0] bv, logic [31:0] sv);
        req_t q;
        q.req_type = op;
        q.a_w = av;
        q.a_x = av;
        q.a_y = av;
        q.a_z = av;
        q.b_w = bv;
        q.b_x = bv;
        q.b_y = bv;
        q.b_z = bv;
        q.scale = sv;
        return q;
    endfunction

    task automatic send_request(input req_t q);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        request <= q;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain_pending();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        int op_code;
        for (op_code = 0; op_code < 16; op_code++)
            send_request(random_request(4'(op_code)));
        send_request(uniform_request(OP_QCONJ, WORD_MIN, WORD_MIN, 32'h0));
        send_request(uniform_request(OP_QPROD, WORD_MIN, WORD_MIN, 32'h0));
        send_request(uniform_request(OP_QPROD, WORD_MAX, WORD_MAX, 32'h0));
        send_request(uniform_request(OP_VDOT, WORD_MAX, WORD_MAX, 32'h0));
        send_request(uniform_request(OP_QSCALE, WORD_MIN, 32'h0, WORD_MIN));
        send_request(uniform_request(OP_VSUB, WORD_MAX, WORD_MIN, 32'h0));
        send_request(uniform_request(OP_QADD, WORD_MIN, WORD_MIN, 32'h0));
        send_request(uniform_request(OP_VGEOM, WORD_MAX, WORD_MIN, 32'h0));
        send_request(uniform_request(OP_QVECPROD, WORD_MIN, WORD_MAX, WORD_MAX));
    endtask

    task automatic run_random(input int count);
        logic [3:0] op;
        for (int n = 0; n < count; n++)
        begin
            op = ($urandom_range(99) < 6) ? OP_QVECPROD + 4'(1 + $urandom_range(1))
                                          : 4'($urandom_range(OP_QVECPROD));
            send_request(random_request(op));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        idle_pct = 0;
        run_directed();
        idle_pct = 23;
        run_random(RANDOM_PER_PHASE);
        drain_pending();
        idle_pct = 59;
        run_random(RANDOM_PER_PHASE);
        drain_pending();
        idle_pct = 0;
        run_random(RANDOM_PER_PHASE);
        drain_pending();
        repeat (8) @(posedge clk);
        $display("%0d requests over all op codes incl. unused ones, %0d results checked",
                 board.request_count, board.result_count);
        $display("%0d saturating results, %0d mismatches, %0d unexpected, %0d missing",
                 board.saturated_count, board.mismatch_count, board.orphan_count,
                 board.pending_results.size());
        if (board.mismatch_count == 0 && board.orphan_count == 0 &&
            board.pending_results.size() == 0)
            $display("quaternion_vector_alu_core_test passed");
        else
            $display("quaternion_vector_alu_core_test failed");
        $finish;
    end

endmodule
